FILE: hw/rtl/tire_force_peak_slip_search_core_defines.svh
// Assertion macros for the peak-slip search core.
`ifndef TIRE_FORCE_PEAK_SLIP_SEARCH_CORE_DEFINES_SVH
`define TIRE_FORCE_PEAK_SLIP_SEARCH_CORE_DEFINES_SVH
// Consequent holds in the cycle after the antecedent.
`define TFP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
// Consequent holds in the same cycle as the antecedent.
`define TFP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`endif

FILE: hw/rtl/tfpss_pkg.sv
// ----------------------------------------------------------------------------
// tfpss_pkg
// Shared types and constants of the peak-slip search core.
// ----------------------------------------------------------------------------
package tfpss_pkg;

    localparam int QW = 24;
    localparam int CW = 42;
    localparam logic signed [23:0] Q_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] Q_MIN = 24'sh800000;
    localparam logic signed [31:0] DEG2RAD_Q30 = 32'sd18740330;
    localparam logic [32:0] PI_Q30 = 33'd3373259426;
    localparam logic signed [31:0] INV2PI_Q32 = 32'sd683565276;
    localparam logic signed [CW-1:0] INVGAIN_Q30 = 42'sd652032874;
    localparam logic signed [CW-1:0] QUARTER = 42'sd1073741824;

    localparam logic [1:0] REG_D = 2'd0;
    localparam logic [1:0] REG_C = 2'd1;
    localparam logic [1:0] REG_B = 2'd2;
    localparam logic [1:0] REG_E = 2'd3;

    typedef struct packed {
        logic signed [23:0] angle;
        logic               last;
    } item_t;

    typedef struct packed {
        logic signed [23:0] force_v;
        logic signed [23:0] angle;
        logic signed [23:0] best;
        logic               last;
    } res_t;

    function automatic logic [31:0] turn_tab(input logic [4:0] i);
        logic [31:0] r;
        begin
            unique case (i)
                5'd0: r = 32'd536870912;  5'd1: r = 32'd316933406;
                5'd2: r = 32'd167458907;  5'd3: r = 32'd85004756;
                5'd4: r = 32'd42667331;   5'd5: r = 32'd21354465;
                5'd6: r = 32'd10679838;   5'd7: r = 32'd5340245;
                5'd8: r = 32'd2670163;    5'd9: r = 32'd1335087;
                5'd10: r = 32'd667544;    5'd11: r = 32'd333772;
                5'd12: r = 32'd166886;    5'd13: r = 32'd83443;
                5'd14: r = 32'd41722;     5'd15: r = 32'd20861;
                5'd16: r = 32'd10430;     5'd17: r = 32'd5215;
                5'd18: r = 32'd2608;      5'd19: r = 32'd1304;
                5'd20: r = 32'd652;       5'd21: r = 32'd326;
                5'd22: r = 32'd163;       5'd23: r = 32'd81;
                5'd24: r = 32'd41;        5'd25: r = 32'd20;
                5'd26: r = 32'd10;        5'd27: r = 32'd5;
                5'd28: r = 32'd3;         5'd29: r = 32'd1;
                5'd30: r = 32'd1;         default: r = 32'd0;
            endcase
            return r;
        end
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
        begin
            if (v > 64'(Q_MAX))
                return Q_MAX;
            else if (v < 64'(Q_MIN))
                return Q_MIN;
            else
                return v[23:0];
        end
    endfunction

endpackage

FILE: hw/rtl/tire_force_peak_slip_search_core.sv
// ----------------------------------------------------------------------------
// tire_force_peak_slip_search_core
// Pacejka lateral force per slip angle with running peak search.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_ready carries slip_angle and is_last; output
// channel out_valid/out_ready carries force_res, best_angle, best_force and
// sweep_end, one result transaction per input transaction.
// A two-entry queue decouples input from the compute engine, so the next
// angles are taken while one is computed or its result waits.
// Each result takes three runs of the single shared CORDIC unit, one step
// per cycle; steps above 32 count as 32. The engine takes no new item from
// the queue until the previous result has been registered for output.
// Coefficients are written on cfg_we/cfg_addr/cfg_wdata while idle: a rule
// that binds the user, as the block itself does not enforce it.
// Reset loads default coefficients and clears the running best.
// A stalled receiver holds the result; the engine waits before the next
// result is written, and the queue fills and drops in_ready.
// ----------------------------------------------------------------------------
`include "tire_force_peak_slip_search_core_defines.svh"
module tire_force_peak_slip_search_core
#(
    parameter int FRAC_BITS    = 16,
    parameter int CORDIC_STEPS = 20
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_addr,
    input  logic [23:0]         cfg_wdata,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic signed [23:0]  slip_angle,
    input  logic                is_last,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [23:0]  force_res,
    output logic signed [23:0]  best_angle,
    output logic signed [23:0]  best_force,
    output logic                sweep_end
);

    logic signed [23:0] cd_reg, cc_reg, cb_reg, ce_reg;
    tfpss_pkg::item_t   in_item, q_item;
    tfpss_pkg::res_t    res;
    logic               q_valid, q_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cd_reg <= 24'sd65536;
            cc_reg <= 24'sd124518;
            cb_reg <= 24'sd655360;
            ce_reg <= 24'sd63570;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                tfpss_pkg::REG_D: cd_reg <= cfg_wdata;
                tfpss_pkg::REG_C: cc_reg <= cfg_wdata;
                tfpss_pkg::REG_B: cb_reg <= cfg_wdata;
                tfpss_pkg::REG_E: ce_reg <= cfg_wdata;
            endcase
        end
    end

    assign in_item.angle = slip_angle;
    assign in_item.last  = is_last;

    tfpss_front u_front
    (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .in_item(in_item), .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
    );

    tfpss_back #(.FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_back
    (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ready(q_ready),
        .q_item(q_item), .coef_d(cd_reg), .coef_c(cc_reg), .coef_b(cb_reg),
        .coef_e(ce_reg), .out_valid(out_valid), .out_ready(out_ready),
        .out_res(res)
    );

    assign force_res  = res.force_v;
    assign best_angle = res.angle;
    assign best_force = res.best;
    assign sweep_end  = res.last;

    `TFP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid,
        "result dropped while stalled")
    `TFP_ASSERT_NEXT(a_out_stable, out_valid && !out_ready,
        $stable(force_res) && $stable(best_angle) && $stable(best_force) && $stable(sweep_end),
        "result changed while stalled")
    `TFP_ASSERT_NOW(a_best_ge, out_valid, best_force >= force_res,
        "best below force")

endmodule

FILE: hw/rtl/tfpss_front.sv
// ----------------------------------------------------------------------------
// tfpss_front
// Input stage and two-entry queue between the front and the compute engine.
// ----------------------------------------------------------------------------
module tfpss_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  tfpss_pkg::item_t     in_item,
    output logic                 q_valid,
    input  logic                 q_ready,
    output tfpss_pkg::item_t     q_item
);

    tfpss_pkg::item_t mem_reg [2];
    logic             wp_reg, wp_next;
    logic             rp_reg, rp_next;
    logic [1:0]       cnt_reg, cnt_next;
    logic             push, pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = mem_reg[rp_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= in_item;
    end

endmodule

FILE: hw/rtl/tfpss_cordic.sv
// ----------------------------------------------------------------------------
// tfpss_cordic
// Iterative CORDIC, one micro-rotation per cycle, vectoring or rotating.
// ----------------------------------------------------------------------------
module tfpss_cordic
#(
    parameter int STEPS = 20
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic                              vec_mode,
    input  logic signed [tfpss_pkg::CW-1:0]   x_in,
    input  logic signed [tfpss_pkg::CW-1:0]   y_in,
    input  logic signed [tfpss_pkg::CW-1:0]   z_in,
    output logic                              done,
    output logic signed [tfpss_pkg::CW-1:0]   y_out,
    output logic signed [tfpss_pkg::CW-1:0]   z_out
);

    localparam int NS = (STEPS > 32) ? 32 : STEPS;

    logic signed [tfpss_pkg::CW-1:0] x_reg, y_reg, z_reg;
    logic [5:0]                      i_reg;
    logic                            busy_reg, mode_reg;
    logic                            dir;
    logic signed [tfpss_pkg::CW-1:0] xs, ys, tv;

    assign xs    = x_reg >>> i_reg;
    assign ys    = y_reg >>> i_reg;
    assign tv    = tfpss_pkg::CW'(signed'({1'b0, tfpss_pkg::turn_tab(i_reg[4:0])}));
    assign dir   = mode_reg ? (y_reg >= 0) : (z_reg >= 0);
    assign done  = busy_reg && (i_reg == 6'(NS));
    assign y_out = y_reg;
    assign z_out = z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            i_reg    <= 6'd0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            i_reg    <= 6'd0;
        end
        else if (done)
            busy_reg <= 1'b0;
        else if (busy_reg)
            i_reg <= i_reg + 6'd1;
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= x_in;
            y_reg    <= y_in;
            z_reg    <= z_in;
            mode_reg <= vec_mode;
        end
        else if (busy_reg && !done)
        begin
            if (mode_reg ^ dir)
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
            end
            else
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
            end
            if (dir)
                z_reg <= mode_reg ? z_reg + tv : z_reg - tv;
            else
                z_reg <= mode_reg ? z_reg - tv : z_reg + tv;
        end
    end

endmodule

FILE: hw/rtl/tfpss_back.sv
// ----------------------------------------------------------------------------
// tfpss_back
// Sequencer for the force formula, peak tracking and the output register.
// ----------------------------------------------------------------------------
module tfpss_back
#(
    parameter int FRAC_BITS    = 16,
    parameter int CORDIC_STEPS = 20
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    output logic                q_ready,
    input  tfpss_pkg::item_t    q_item,
    input  logic signed [23:0]  coef_d,
    input  logic signed [23:0]  coef_c,
    input  logic signed [23:0]  coef_b,
    input  logic signed [23:0]  coef_e,
    output logic                out_valid,
    input  logic                out_ready,
    output tfpss_pkg::res_t     out_res
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RAD  = 4'd1;
    localparam logic [3:0] S_BX   = 4'd2;
    localparam logic [3:0] S_AT1  = 4'd3;
    localparam logic [3:0] S_AT1W = 4'd4;
    localparam logic [3:0] S_EM   = 4'd5;
    localparam logic [3:0] S_AT2  = 4'd6;
    localparam logic [3:0] S_AT2W = 4'd7;
    localparam logic [3:0] S_CM   = 4'd8;
    localparam logic [3:0] S_SIN  = 4'd9;
    localparam logic [3:0] S_SINW = 4'd10;
    localparam logic [3:0] S_DM   = 4'd11;
    localparam logic [3:0] S_OUT  = 4'd12;
    localparam int SH = 61 - FRAC_BITS;

    logic [3:0]          st_reg;
    tfpss_pkg::item_t    it_reg;
    logic signed [23:0]  bx_reg, acc_reg;
    logic signed [23:0]  pk_f_reg, pk_a_reg;
    logic                seen_reg, flip_reg;
    logic                ov_reg;
    tfpss_pkg::res_t     res_reg;

    logic                c_start, c_vec, c_done;
    logic signed [tfpss_pkg::CW-1:0] c_x, c_y, c_z, c_yo, c_zo;
    logic signed [23:0]  ma, mb;
    logic signed [47:0]  mp;
    logic signed [23:0]  mq;
    logic signed [23:0]  at_q, sin_q;
    logic signed [55:0]  rad_p;
    logic signed [23:0]  rad_q;
    logic [31:0]         t_turn;
    logic [31:0]         t_fold;
    logic                t_flip;
    logic                upd;
    logic                pub;

    function automatic logic signed [63:0] rshift(input logic signed [63:0] v,
                                                  input int s);
        logic [63:0] m;
        logic [63:0] r;
        begin
            m = v[63] ? 64'(-v) : 64'(v);
            r = (m + (64'd1 << (s - 1))) >> s;
            return v[63] ? -$signed(r) : $signed(r);
        end
    endfunction

    tfpss_cordic #(.STEPS(CORDIC_STEPS)) u_cordic
    (
        .clk(clk), .rst_n(rst_n), .start(c_start), .vec_mode(c_vec),
        .x_in(c_x), .y_in(c_y), .z_in(c_z),
        .done(c_done), .y_out(c_yo), .z_out(c_zo)
    );

    always_comb
    begin
        ma = coef_b;
        mb = acc_reg;
        unique case (st_reg)
            S_EM:    ma = coef_e;
            S_CM:    ma = coef_c;
            S_DM:    ma = coef_d;
            default: ma = coef_b;
        endcase
    end

    assign mp    = ma * mb;
    assign mq    = tfpss_pkg::sat24(rshift(64'(mp), FRAC_BITS));
    assign rad_p = it_reg.angle * tfpss_pkg::DEG2RAD_Q30;
    assign rad_q = tfpss_pkg::sat24(rshift(64'(rad_p), 30));

    always_comb
    begin
        logic [63:0] zm;
        logic [63:0] r;
        logic signed [63:0] tp;
        zm     = c_zo[tfpss_pkg::CW-1] ? 64'(-c_zo) : 64'(c_zo);
        r      = (zm * 64'(tfpss_pkg::PI_Q30) + (64'd1 << (SH - 1))) >> SH;
        at_q   = tfpss_pkg::sat24(c_zo[tfpss_pkg::CW-1] ? -$signed(r) : $signed(r));
        tp     = 64'(acc_reg) * 64'(tfpss_pkg::INV2PI_Q32);
        t_turn = 32'(tp >>> FRAC_BITS);
        t_flip = (t_turn >= 32'h40000000) && (t_turn < 32'hC0000000);
        t_fold = t_flip ? t_turn - 32'h80000000 : t_turn;
        sin_q  = tfpss_pkg::sat24(rshift(64'(c_yo), 30 - FRAC_BITS));
        sin_q  = flip_reg ? tfpss_pkg::sat24(-64'(sin_q)) : sin_q;
    end

    always_comb
    begin
        c_start = 1'b0;
        c_vec   = 1'b1;
        c_x     = tfpss_pkg::QUARTER;
        c_y     = tfpss_pkg::CW'(acc_reg) <<< (30 - FRAC_BITS);
        c_z     = '0;
        unique case (st_reg)
            S_AT1, S_AT2: c_start = 1'b1;
            S_SIN:
            begin
                c_start = 1'b1;
                c_vec   = 1'b0;
                c_x     = tfpss_pkg::INVGAIN_Q30;
                c_y     = '0;
                c_z     = tfpss_pkg::CW'(signed'(t_fold));
            end
            default: c_start = 1'b0;
        endcase
    end

    // acc_reg holds the force while in S_OUT
    assign upd = !seen_reg || (acc_reg > pk_f_reg) ||
                 ((acc_reg == pk_f_reg) && (it_reg.angle < pk_a_reg));
    assign pub       = (st_reg == S_OUT) && (!ov_reg || out_ready);
    assign q_ready   = (st_reg == S_IDLE);
    assign out_valid = ov_reg;
    assign out_res   = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= S_IDLE;
            ov_reg   <= 1'b0;
            seen_reg <= 1'b0;
            pk_f_reg <= tfpss_pkg::Q_MIN;
            pk_a_reg <= tfpss_pkg::Q_MAX;
        end
        else
        begin
            if (pub)
                ov_reg <= 1'b1;
            else if (out_valid && out_ready)
                ov_reg <= 1'b0;
            unique case (st_reg)
                S_IDLE: if (q_valid) st_reg <= S_RAD;
                S_RAD:  st_reg <= S_BX;
                S_BX:   st_reg <= S_AT1;
                S_AT1:  st_reg <= S_AT1W;
                S_AT1W: if (c_done) st_reg <= S_EM;
                S_EM:   st_reg <= S_AT2;
                S_AT2:  st_reg <= S_AT2W;
                S_AT2W: if (c_done) st_reg <= S_CM;
                S_CM:   st_reg <= S_SIN;
                S_SIN:  st_reg <= S_SINW;
                S_SINW: if (c_done) st_reg <= S_DM;
                S_DM:   st_reg <= S_OUT;
                S_OUT:
                begin
                    if (pub)
                    begin
                        st_reg <= S_IDLE;
                        if (it_reg.last)
                        begin
                            seen_reg <= 1'b0;
                            pk_f_reg <= tfpss_pkg::Q_MIN;
                            pk_a_reg <= tfpss_pkg::Q_MAX;
                        end
                        else if (upd)
                        begin
                            seen_reg <= 1'b1;
                            pk_f_reg <= acc_reg;
                            pk_a_reg <= it_reg.angle;
                        end
                    end
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (st_reg)
            S_IDLE: if (q_valid) it_reg <= q_item;
            S_RAD:  acc_reg <= rad_q;
            S_BX:
            begin
                acc_reg <= mq;
                bx_reg  <= mq;
            end
            S_AT1W: if (c_done)
                acc_reg <= tfpss_pkg::sat24(64'(bx_reg) - 64'(at_q));
            S_EM:   acc_reg <= tfpss_pkg::sat24(64'(bx_reg) - 64'(mq));
            S_AT2W: if (c_done) acc_reg <= at_q;
            S_CM:
            begin
                acc_reg  <= mq;
            end
            S_SIN:  flip_reg <= t_flip;
            S_SINW: if (c_done) acc_reg <= sin_q;
            S_DM:   acc_reg <= mq;
            S_OUT:
            begin
                if (pub)
                begin
                    res_reg.force_v <= acc_reg;
                    res_reg.angle   <= upd ? it_reg.angle : pk_a_reg;
                    res_reg.best    <= upd ? acc_reg : pk_f_reg;
                    res_reg.last    <= it_reg.last;
                end
            end
            default: ;
        endcase
    end

endmodule
